### rtl/arp_pkg.sv
`timescale 1ns / 1ps
package arp_pkg;
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] FUNC_RECV = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_BUILD = 2'd2;

    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4 = 16'h0800;
    localparam logic [15:0] OP_REQUEST = 16'h0001;
    localparam logic [15:0] OP_REPLY = 16'h0002;
    localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

    localparam logic [3:0] ST_REPLY = 4'd0;
    localparam logic [3:0] ST_REQUEST = 4'd1;
    localparam logic [3:0] ST_HIT = 4'd2;
    localparam logic [3:0] ST_MISS = 4'd3;
    localparam logic [3:0] ST_BAD_HW = 4'd4;
    localparam logic [3:0] ST_BAD_PROTO = 4'd5;
    localparam logic [3:0] ST_NOT_OURS = 4'd6;
    localparam logic [3:0] ST_FULL = 4'd7;
    localparam logic [3:0] ST_BAD_OP = 4'd8;

    localparam logic [0:0] CFG_LOCAL_IP = 1'd0;
    localparam logic [0:0] CFG_LOCAL_MAC = 1'd1;

    // class the front end assigns to an item
    typedef enum logic [1:0] {
        CMD_DONE,
        CMD_RECV,
        CMD_LOOKUP
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [3:0]  status;
        logic [15:0] arp_op;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FINISH,
        BK_OUT
    } bk_state_t;
endpackage

### rtl/arp_front.sv
`timescale 1ns / 1ps
module arp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    func,
    input  logic [15:0]   hw_type,
    input  logic [15:0]   proto_type,
    input  logic [15:0]   arp_op,
    input  logic [47:0]   sender_mac,
    input  logic [31:0]   sender_ip,
    input  logic [31:0]   target_ip,
    output logic          job_valid,
    input  logic          job_ready,
    output arp_pkg::job_t job
);
    import arp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t             q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    job_t             cls;
    logic             push, pop;

    // classify: checks that need no cache access are settled here
    always_comb
    begin
        cls.cmd = CMD_DONE;
        cls.status = ST_BAD_OP;
        cls.arp_op = arp_op;
        cls.sender_mac = sender_mac;
        cls.sender_ip = sender_ip;
        cls.target_ip = target_ip;
        unique case (func)
            FUNC_RECV:
            begin
                if (hw_type != HW_ETHERNET)
                    cls.status = ST_BAD_HW;
                else if (proto_type != PROTO_IPV4)
                    cls.status = ST_BAD_PROTO;
                else
                    cls.cmd = CMD_RECV;
            end
            FUNC_LOOKUP: cls.cmd = CMD_LOOKUP;
            FUNC_BUILD:  cls.status = ST_REQUEST;
            default:     cls.status = ST_BAD_OP;
        endcase
    end

    assign in_ready  = (cnt_reg != (PTR_W + 1)'(QUEUE_DEPTH));
    assign job_valid = (cnt_reg != '0);
    assign job       = q_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = job_valid && job_ready;

    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= cls;
    end
endmodule

### rtl/arp_back.sv
`timescale 1ns / 1ps
module arp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  arp_pkg::job_t job,
    input  logic [31:0]   local_ip,
    input  logic [47:0]   local_mac,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [3:0]    status,
    output logic [47:0]   eth_dest,
    output logic [15:0]   out_op,
    output logic [15:0]   out_hw_type,
    output logic [15:0]   out_proto_type,
    output logic [47:0]   out_sender_mac,
    output logic [31:0]   out_sender_ip,
    output logic [47:0]   out_target_mac,
    output logic [31:0]   out_target_ip,
    output logic [47:0]   found_mac
);
    import arp_pkg::*;

    logic [31:0]      ip_mem [TABLE_ENTRIES];
    logic [47:0]      mac_mem [TABLE_ENTRIES];

    bk_state_t        state_reg, state_next;
    job_t             job_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [31:0]      rd_ip_reg;
    logic [47:0]      rd_mac_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_en;
    logic             ip_we, mac_we;
    logic [IDX_W-1:0] wr_idx;
    logic [3:0]       st_reg, st_next;
    logic [47:0]      fmac_reg, fmac_next;
    logic             take;

    assign job_ready = (state_reg == BK_IDLE);
    assign take = job_valid && job_ready;
    // one entry read per cycle while scanning
    assign rd_en = (state_reg == BK_SCAN) && (scan_reg < count_reg) && !hit_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (take)
                    state_next = (job.cmd == CMD_DONE) ? BK_OUT : BK_SCAN;
            BK_SCAN:
                if (!rd_en && !rd_vld_reg)
                    state_next = BK_FINISH;
            BK_FINISH: state_next = BK_OUT;
            BK_OUT:
                if (out_ready)
                    state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        scan_next = scan_reg;
        hit_next = hit_reg;
        hit_idx_next = hit_idx_reg;
        count_next = count_reg;
        st_next = st_reg;
        fmac_next = fmac_reg;
        ip_we = 1'b0;
        mac_we = 1'b0;
        wr_idx = hit_idx_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                scan_next = '0;
                hit_next = 1'b0;
                st_next = job.status;
                fmac_next = '0;
            end
            BK_SCAN:
            begin
                if (rd_en)
                    scan_next = scan_reg + 1'b1;
                if (rd_vld_reg && !hit_reg && rd_ip_reg == job_reg.sender_ip)
                begin
                    hit_next = 1'b1;
                    hit_idx_next = rd_idx_reg;
                end
            end
            BK_FINISH:
            begin
                if (job_reg.cmd == CMD_LOOKUP)
                begin
                    st_next = hit_reg ? ST_HIT : ST_MISS;
                    fmac_next = rd_mac_reg;
                end
                else
                begin
                    mac_we = hit_reg;
                    if (job_reg.target_ip != local_ip)
                        st_next = ST_NOT_OURS;
                    else if (!hit_reg && count_reg >= CNT_W'(TABLE_ENTRIES))
                        st_next = ST_FULL;
                    else
                    begin
                        if (!hit_reg)
                        begin
                            ip_we = 1'b1;
                            mac_we = 1'b1;
                            wr_idx = count_reg[IDX_W-1:0];
                            count_next = count_reg + 1'b1;
                        end
                        st_next = (job_reg.arp_op == OP_REQUEST) ? ST_REPLY : ST_BAD_OP;
                    end
                end
            end
            BK_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            count_reg <= '0;
            scan_reg <= '0;
            hit_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg <= scan_next;
            hit_reg <= hit_next;
            rd_vld_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            job_reg <= job;
        hit_idx_reg <= hit_idx_next;
        st_reg <= st_next;
        fmac_reg <= fmac_next;
        rd_idx_reg <= scan_reg[IDX_W-1:0];
        if (rd_en)
            rd_ip_reg <= ip_mem[scan_reg[IDX_W-1:0]];
        // on leaving scan, the read port fetches the hit mac, which finish uses for a lookup
        if (state_reg == BK_SCAN && state_next == BK_FINISH)
            rd_mac_reg <= mac_mem[hit_idx_next];
        if (ip_we)
            ip_mem[wr_idx] <= job_reg.sender_ip;
        if (mac_we)
            mac_mem[wr_idx] <= job_reg.sender_mac;
    end

    logic frame, req;
    assign frame = (st_reg == ST_REPLY) || (st_reg == ST_REQUEST);
    assign req = (st_reg == ST_REQUEST);

    assign out_valid      = (state_reg == BK_OUT);
    assign status         = st_reg;
    assign found_mac      = (st_reg == ST_HIT) ? fmac_reg : '0;
    assign eth_dest       = !frame ? '0 : req ? BCAST_MAC : job_reg.sender_mac;
    assign out_op         = !frame ? '0 : req ? OP_REQUEST : OP_REPLY;
    assign out_hw_type    = frame ? HW_ETHERNET : '0;
    assign out_proto_type = frame ? PROTO_IPV4 : '0;
    assign out_sender_mac = frame ? local_mac : '0;
    assign out_sender_ip  = !frame ? '0 : req ? job_reg.sender_ip : local_ip;
    assign out_target_mac = !frame ? '0 : req ? BCAST_MAC : job_reg.sender_mac;
    assign out_target_ip  = !frame ? '0 : req ? job_reg.target_ip : job_reg.sender_ip;
endmodule

### rtl/arp_responder_with_cache_unit.sv
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | func .. target_ip
// out     | output    | out_valid / out_ready | status .. found_mac
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// a packet or lookup walks the cached entries in the back end's scan state, then
// settles in finish and shows its result in the out state, holding it until out_ready;
// one cache entry is compared per cycle by the back end's single comparator,
// and a match stops the walk early
// a build request or early drop skips the scan and goes straight to the out state;
// after each result the back end returns to idle, where it takes the next item
// reset empties the cache at once (entry count to zero), no clearing pass
// a two-deep item queue lets the front accept while the back end scans or
// waits on out_ready
module arp_responder_with_cache_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [15:0] hw_type,
    input  logic [15:0] proto_type,
    input  logic [15:0] arp_op,
    input  logic [47:0] sender_mac,
    input  logic [31:0] sender_ip,
    input  logic [31:0] target_ip,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [47:0] eth_dest,
    output logic [15:0] out_op,
    output logic [15:0] out_hw_type,
    output logic [15:0] out_proto_type,
    output logic [47:0] out_sender_mac,
    output logic [31:0] out_sender_ip,
    output logic [47:0] out_target_mac,
    output logic [31:0] out_target_ip,
    output logic [47:0] found_mac,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import arp_pkg::*;

    logic        job_valid, job_ready;
    job_t        job;
    logic [31:0] local_ip_reg;
    logic [47:0] local_mac_reg;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg <= '0;
            local_mac_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LOCAL_IP:  local_ip_reg <= cfg_data[31:0];
                CFG_LOCAL_MAC: local_mac_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // front end: classify and queue
    arp_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .hw_type(hw_type), .proto_type(proto_type), .arp_op(arp_op),
        .sender_mac(sender_mac), .sender_ip(sender_ip), .target_ip(target_ip),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    // back end: cache scan, update and result
    arp_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .local_ip(local_ip_reg), .local_mac(local_mac_reg),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .eth_dest(eth_dest), .out_op(out_op),
        .out_hw_type(out_hw_type), .out_proto_type(out_proto_type),
        .out_sender_mac(out_sender_mac), .out_sender_ip(out_sender_ip),
        .out_target_mac(out_target_mac), .out_target_ip(out_target_ip),
        .found_mac(found_mac)
    );
endmodule

### rtl/arp_checker.sv
`timescale 1ns / 1ps
module arp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  status,
    input logic [47:0] found_mac,
    input logic [15:0] out_op,
    input logic [15:0] out_hw_type
);
    import arp_pkg::*;

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_BAD_OP)
        else $error("status out of range");

    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_HIT) |-> found_mac == '0)
        else $error("found_mac set without hit");

    a_frame_op: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_REPLY || status == ST_REQUEST)) |->
            (out_hw_type == HW_ETHERNET && (out_op == OP_REPLY || out_op == OP_REQUEST)))
        else $error("bad frame header");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status)))
        else $error("result dropped under stall");
endmodule

bind arp_responder_with_cache_unit arp_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .found_mac(found_mac), .out_op(out_op),
    .out_hw_type(out_hw_type)
);

### tb/sv/arp_scoreboard.sv
`timescale 1ns / 1ps
module arp_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  func,
    input  logic [15:0] hw_type,
    input  logic [15:0] proto_type,
    input  logic [15:0] arp_op,
    input  logic [47:0] sender_mac,
    input  logic [31:0] sender_ip,
    input  logic [31:0] target_ip,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [3:0]  status,
    input  logic [47:0] eth_dest,
    input  logic [15:0] out_op,
    input  logic [15:0] out_hw_type,
    input  logic [15:0] out_proto_type,
    input  logic [47:0] out_sender_mac,
    input  logic [31:0] out_sender_ip,
    input  logic [47:0] out_target_mac,
    input  logic [31:0] out_target_ip,
    input  logic [47:0] found_mac,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [47:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    import arp_pkg::*;

    typedef struct packed {
        logic [3:0]  status;
        logic [47:0] eth_dest;
        logic [15:0] op;
        logic [15:0] hw;
        logic [15:0] proto;
        logic [47:0] smac;
        logic [31:0] sip;
        logic [47:0] tmac;
        logic [31:0] tip;
        logic [47:0] found;
    } arp_result_t;

    logic [31:0] my_ip;
    logic [47:0] my_mac;
    logic [31:0] cache_ip [TABLE_ENTRIES];
    logic [47:0] cache_mac [TABLE_ENTRIES];
    int          cache_used;
    arp_result_t replies_due [$];

    assign pending = replies_due.size();

    function automatic int cache_find(logic [31:0] ip);
        for (int i = 0; i < cache_used; i++)
            if (cache_ip[i] == ip)
                return i;
        return -1;
    endfunction

    function automatic arp_result_t frame(logic [3:0] st, logic [47:0] dest,
                                          logic [15:0] op, logic [31:0] sip,
                                          logic [47:0] tmac, logic [31:0] tip);
        arp_result_t r;
        r = '0;
        r.status = st;
        r.eth_dest = dest;
        r.op = op;
        r.hw = HW_ETHERNET;
        r.proto = PROTO_IPV4;
        r.smac = my_mac;
        r.sip = sip;
        r.tmac = tmac;
        r.tip = tip;
        return r;
    endfunction

    // updates the cache and returns the expected answer
    function automatic arp_result_t resolve_item();
        arp_result_t r;
        int hit;
        r = '0;
        case (func)
            FUNC_RECV:
            begin
                if (hw_type != HW_ETHERNET)
                    r.status = ST_BAD_HW;
                else if (proto_type != PROTO_IPV4)
                    r.status = ST_BAD_PROTO;
                else
                begin
                    hit = cache_find(sender_ip);
                    if (hit >= 0)
                        cache_mac[hit] = sender_mac;
                    if (target_ip != my_ip)
                        r.status = ST_NOT_OURS;
                    else if (hit < 0 && cache_used >= TABLE_ENTRIES)
                        r.status = ST_FULL;
                    else
                    begin
                        if (hit < 0)
                        begin
                            cache_ip[cache_used] = sender_ip;
                            cache_mac[cache_used] = sender_mac;
                            cache_used++;
                        end
                        if (arp_op != OP_REQUEST)
                            r.status = ST_BAD_OP;
                        else
                            r = frame(ST_REPLY, sender_mac, OP_REPLY, my_ip,
                                      sender_mac, sender_ip);
                    end
                end
            end
            FUNC_LOOKUP:
            begin
                hit = cache_find(sender_ip);
                if (hit >= 0)
                begin
                    r.status = ST_HIT;
                    r.found = cache_mac[hit];
                end
                else
                    r.status = ST_MISS;
            end
            FUNC_BUILD:
                r = frame(ST_REQUEST, BCAST_MAC, OP_REQUEST, sender_ip, BCAST_MAC,
                          target_ip);
            default:
                r.status = ST_BAD_OP;
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        arp_result_t e;
        if (!rst_n)
        begin
            my_ip = '0;
            my_mac = '0;
            cache_used = 0;
            fail_count = 0;
            replies_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_LOCAL_IP)
                    my_ip = cfg_data[31:0];
                else
                    my_mac = cfg_data;
            end
            if (in_valid && in_ready)
                replies_due.push_back(resolve_item());
            if (out_valid && out_ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("result with nothing expected, status %0h", status);
                    fail_count++;
                end
                else
                begin
                    e = replies_due.pop_front();
                    check_field("status", 64'(e.status), 64'(status));
                    check_field("eth_dest", 64'(e.eth_dest), 64'(eth_dest));
                    check_field("out_op", 64'(e.op), 64'(out_op));
                    check_field("out_hw_type", 64'(e.hw), 64'(out_hw_type));
                    check_field("out_proto_type", 64'(e.proto), 64'(out_proto_type));
                    check_field("out_sender_mac", 64'(e.smac), 64'(out_sender_mac));
                    check_field("out_sender_ip", 64'(e.sip), 64'(out_sender_ip));
                    check_field("out_target_mac", 64'(e.tmac), 64'(out_target_mac));
                    check_field("out_target_ip", 64'(e.tip), 64'(out_target_ip));
                    check_field("found_mac", 64'(e.found), 64'(found_mac));
                end
            end
        end
    end
endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import arp_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = '0;
    logic [15:0] hw_type = '0;
    logic [15:0] proto_type = '0;
    logic [15:0] arp_op = '0;
    logic [47:0] sender_mac = '0;
    logic [31:0] sender_ip = '0;
    logic [31:0] target_ip = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  status;
    logic [47:0] eth_dest, out_sender_mac, out_target_mac, found_mac;
    logic [15:0] out_op, out_hw_type, out_proto_type;
    logic [31:0] out_sender_ip, out_target_ip;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    logic        drain_busy = 1'b1;

    // ip pool kept small so merges, hits and a full table all happen often
    logic [31:0] my_ip_now;
    logic [31:0] ip_pool [24];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    arp_responder_with_cache_unit dut (.*);

    arp_scoreboard checker_i (.*);

    // half of the gaps are zero, most others short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receive side stalls on its own schedule
    always @(posedge clk)
    begin
        int g;
        if (drain_busy)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            g = gap_len();
            out_ready <= (g == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    // watchdog: any cycle without a handshake counts toward the limit
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [47:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_LOCAL_IP)
            my_ip_now = data[31:0];
    endtask

    task automatic send_item(logic [1:0] f, logic [15:0] hw, logic [15:0] pr,
                             logic [15:0] op, logic [47:0] smac, logic [31:0] sip,
                             logic [31:0] tip);
        func <= f;
        hw_type <= hw;
        proto_type <= pr;
        arp_op <= op;
        sender_mac <= smac;
        sender_ip <= sip;
        target_ip <= tip;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        // keep valid high across back-to-back items
        if (gap_len() != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
    endtask

    // wait for every result, plus slack for the longest table scan
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [47:0] rand_mac();
        return {16'($urandom()), $urandom()};
    endfunction

    // one random item, weighted toward well-formed packets
    task automatic random_item();
        int k;
        logic [31:0] sip, tip;
        logic [15:0] hw, pr, op;
        k = $urandom_range(0, 99);
        sip = ($urandom_range(0, 9) == 0) ? $urandom() : ip_pool[$urandom_range(0, 23)];
        tip = ($urandom_range(0, 4) == 0) ? $urandom() : my_ip_now;
        hw = ($urandom_range(0, 19) == 0) ? 16'($urandom()) : HW_ETHERNET;
        pr = ($urandom_range(0, 19) == 0) ? 16'($urandom()) : PROTO_IPV4;
        op = ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
             (($urandom_range(0, 3) == 0) ? OP_REPLY : OP_REQUEST);
        if (k < 55)
            send_item(FUNC_RECV, hw, pr, op, rand_mac(), sip, tip);
        else if (k < 80)
            send_item(FUNC_LOOKUP, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                      rand_mac(), sip, $urandom());
        else if (k < 95)
            send_item(FUNC_BUILD, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                      rand_mac(), $urandom(), $urandom());
        else
            send_item(2'd3, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                      rand_mac(), $urandom(), $urandom());
    endtask

    initial
    begin
        my_ip_now = '0;
        foreach (ip_pool[i])
            ip_pool[i] = $urandom();
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: local ip zero, so a zero target is ours
        send_item(FUNC_LOOKUP, 0, 0, 0, 0, 32'h0, 0);
        send_item(FUNC_RECV, HW_ETHERNET, PROTO_IPV4, OP_REQUEST, '1, 32'h0, 32'h0);
        drain();
        write_reg(CFG_LOCAL_IP, 48'hFFFF_FFFF);
        write_reg(CFG_LOCAL_MAC, 48'hFFFF_FFFF_FFFF);

        // bad hw, bad proto, every opcode, not ours with merge, field extremes
        send_item(FUNC_RECV, 16'h0000, PROTO_IPV4, OP_REQUEST, 48'h1, 32'h5, '1);
        send_item(FUNC_RECV, 16'hFFFF, PROTO_IPV4, OP_REQUEST, 48'h1, 32'h5, '1);
        send_item(FUNC_RECV, HW_ETHERNET, 16'hFFFF, OP_REQUEST, 48'h1, 32'h5, '1);
        send_item(FUNC_RECV, HW_ETHERNET, PROTO_IPV4, OP_REPLY, 48'h1, 32'h5, '1);
        send_item(FUNC_RECV, HW_ETHERNET, PROTO_IPV4, 16'hFFFF, 48'h2, 32'h6, '1);
        send_item(FUNC_RECV, HW_ETHERNET, PROTO_IPV4, OP_REQUEST, 48'hAA, 32'h5, 32'h0);
        send_item(FUNC_LOOKUP, 0, 0, 0, 0, 32'h5, 0);
        send_item(FUNC_LOOKUP, '1, '1, '1, '1, 32'h7, '1);
        send_item(FUNC_BUILD, 0, 0, 0, 0, '1, '1);
        send_item(FUNC_BUILD, '1, '1, '1, '1, 0, 0);
        send_item(2'd3, '1, '1, '1, '1, '1, '1);
        drain();

        // fill the table past full, then look up the first and last
        write_reg(CFG_LOCAL_MAC, 48'h0);
        for (int i = 0; i < TABLE_ENTRIES + 2; i++)
            send_item(FUNC_RECV, HW_ETHERNET, PROTO_IPV4, OP_REQUEST, rand_mac(),
                      32'h100 + i, '1);
        send_item(FUNC_LOOKUP, 0, 0, 0, 0, 32'h100, 0);
        send_item(FUNC_LOOKUP, 0, 0, 0, 0, 32'h100 + TABLE_ENTRIES + 1, 0);
        drain();

        // random phases with fresh settings; the table stays full from the fill
        // above, so hits and misses still come through merges
        drain_busy = 1'b0;
        for (int p = 0; p < 6; p++)
        begin
            write_reg(CFG_LOCAL_IP, (p == 5) ? 48'h0 : {16'h0, $urandom()});
            write_reg(CFG_LOCAL_MAC, (p == 4) ? 48'hFFFF_FFFF_FFFF : rand_mac());
            foreach (ip_pool[i])
                if ($urandom_range(0, 3) == 0)
                    ip_pool[i] = $urandom();
            repeat (215) random_item();
            drain();
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

### arp_responder_with_cache_unit.f
rtl/arp_pkg.sv
rtl/arp_front.sv
rtl/arp_back.sv
rtl/arp_responder_with_cache_unit.sv
rtl/arp_checker.sv
tb/sv/arp_scoreboard.sv
tb/sv/testbench.sv
